// ===== rtl/sptgp_pkg.sv =====
`timescale 1ns / 1ps

package sptgp_pkg;

   localparam int MAX_IMAGE_SIDE = 1024;
   localparam int CORDIC_STEPS = 16;
   localparam int OFFSET_FRAC = 46;

   localparam int ANGLE_W = 32;
   localparam int VECTOR_W = 33;
   localparam int SCALE_W = 32;
   localparam int PRODUCT_W = 66;
   localparam int PIXEL_W = PRODUCT_W - OFFSET_FRAC;
   localparam int SIDE_W = 11;

   localparam logic signed [ANGLE_W-1:0] ANG_PI = 32'sd843314857;
   localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 32'sd421657428;
   localparam logic signed [VECTOR_W-1:0] CORDIC_GAIN = 33'sd652032874;

   localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
      32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
      32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
      32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192
   };

   localparam logic [2:0] CSR_ORIGIN_COL = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_ROW = 3'd1;
   localparam logic [2:0] CSR_CELLS_PER_METRE = 3'd2;
   localparam logic [2:0] CSR_IMAGE_COLS = 3'd3;
   localparam logic [2:0] CSR_IMAGE_ROWS = 3'd4;

   typedef struct packed {
      logic [15:0] range_q8;
      logic signed [15:0] bearing_q13;
      logic reading_invalid;
      logic last_sample;
   } req_type;

   typedef struct packed {
      logic [9:0] pixel_col;
      logic [9:0] pixel_row;
      logic point_kept;
      logic scan_end;
   } rsp_type;

endpackage

// ===== rtl/scan_point_to_grid_pixel_core.sv =====
`timescale 1ns / 1ps

// Projects range-finder samples onto an image grid.
// Each request transaction carries one sample (range, bearing, invalid flag and
// end-of-scan flag) and produces exactly one response transaction with the pixel
// column and row, a kept flag and a copy of the end-of-scan flag.
// Both channels use valid/ready. The datapath is a 20-stage pipeline: a
// quadrant fold and range scaling stage, one stage per CORDIC iteration (16),
// a multiply stage, an origin add stage and an output stage that truncates and
// checks the image bounds. One request can be accepted every cycle while the
// receiver is not stalling.
// When the receiver stalls, the whole pipeline holds and req_ready drops in the
// same cycle, so nothing is lost or repeated; bubbles travel with the data.
// The configuration port writes origin, scale and image size registers; it is
// to be used only while the pipeline is empty, which the block does not enforce.
// Reset clears all valid bits and loads the default registers: origin column
// 100, origin row 185, 20 cells per metre and a 200 by 200 image.
module scan_point_to_grid_pixel_core
   import sptgp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [9:0] origin_col_ff;
   logic [9:0] origin_row_ff;
   logic [15:0] cells_per_metre_ff;
   logic [SIDE_W-1:0] image_cols_ff;
   logic [SIDE_W-1:0] image_rows_ff;

   logic advance;

   logic signed [ANGLE_W-1:0] angle;
   logic signed [ANGLE_W-1:0] angle_fold;
   logic flip_fold;

   logic valid_ff [CORDIC_STEPS+1];
   logic flip_ff [CORDIC_STEPS+1];
   logic invalid_ff [CORDIC_STEPS+1];
   logic last_ff [CORDIC_STEPS+1];
   logic [SCALE_W-1:0] scale_ff [CORDIC_STEPS+1];
   logic signed [VECTOR_W-1:0] x_ff [CORDIC_STEPS+1];
   logic signed [VECTOR_W-1:0] y_ff [CORDIC_STEPS+1];
   logic signed [ANGLE_W-1:0] z_ff [CORDIC_STEPS+1];
   logic signed [VECTOR_W-1:0] x_in [CORDIC_STEPS+1];
   logic signed [VECTOR_W-1:0] y_in [CORDIC_STEPS+1];
   logic signed [ANGLE_W-1:0] z_in [CORDIC_STEPS+1];

   logic mul_valid_ff;
   logic mul_flip_ff;
   logic mul_invalid_ff;
   logic mul_last_ff;
   logic signed [PRODUCT_W-1:0] px_ff;
   logic signed [PRODUCT_W-1:0] py_ff;
   logic signed [PRODUCT_W-1:0] px_in;
   logic signed [PRODUCT_W-1:0] py_in;

   logic add_valid_ff;
   logic add_invalid_ff;
   logic add_last_ff;
   logic signed [PRODUCT_W-1:0] dc_ff;
   logic signed [PRODUCT_W-1:0] dr_ff;
   logic signed [PRODUCT_W-1:0] dc_in;
   logic signed [PRODUCT_W-1:0] dr_in;
   logic signed [PRODUCT_W-1:0] base_col;
   logic signed [PRODUCT_W-1:0] base_row;

   logic signed [PIXEL_W-1:0] qc;
   logic signed [PIXEL_W-1:0] qr;
   logic [SIDE_W-1:0] wmax;
   logic [SIDE_W-1:0] hmax;
   logic kept;

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_col_ff <= 10'd100;
         origin_row_ff <= 10'd185;
         cells_per_metre_ff <= 16'd5120;
         image_cols_ff <= 11'd200;
         image_rows_ff <= 11'd200;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_COL: origin_col_ff <= csr_wdata[9:0];
            CSR_ORIGIN_ROW: origin_row_ff <= csr_wdata[9:0];
            CSR_CELLS_PER_METRE: cells_per_metre_ff <= csr_wdata;
            CSR_IMAGE_COLS: image_cols_ff <= csr_wdata[SIDE_W-1:0];
            CSR_IMAGE_ROWS: image_rows_ff <= csr_wdata[SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      angle = {req_data.bearing_q13[15], req_data.bearing_q13, 15'd0};
      angle_fold = angle;
      flip_fold = 1'b0;
      if (angle > ANG_HALF_PI) begin
         angle_fold = angle - ANG_PI;
         flip_fold = 1'b1;
      end else if (angle < -ANG_HALF_PI) begin
         angle_fold = angle + ANG_PI;
         flip_fold = 1'b1;
      end
   end

   always_comb begin
      x_in[0] = CORDIC_GAIN;
      y_in[0] = '0;
      z_in[0] = angle_fold;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (!z_ff[i][ANGLE_W-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ATAN_TABLE[i];
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ATAN_TABLE[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flip_ff[0] <= flip_fold;
         invalid_ff[0] <= req_data.reading_invalid;
         last_ff[0] <= req_data.last_sample;
         scale_ff[0] <= SCALE_W'(req_data.range_q8) * SCALE_W'(cells_per_metre_ff);
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            flip_ff[i] <= flip_ff[i-1];
            invalid_ff[i] <= invalid_ff[i-1];
            last_ff[i] <= last_ff[i-1];
            scale_ff[i] <= scale_ff[i-1];
         end
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign px_in = PRODUCT_W'($signed({1'b0, scale_ff[CORDIC_STEPS]}))
      * PRODUCT_W'(y_ff[CORDIC_STEPS]);
   assign py_in = PRODUCT_W'($signed({1'b0, scale_ff[CORDIC_STEPS]}))
      * PRODUCT_W'(x_ff[CORDIC_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= valid_ff[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_flip_ff <= flip_ff[CORDIC_STEPS];
         mul_invalid_ff <= invalid_ff[CORDIC_STEPS];
         mul_last_ff <= last_ff[CORDIC_STEPS];
         px_ff <= px_in;
         py_ff <= py_in;
      end
   end

   assign base_col = $signed(PRODUCT_W'({origin_col_ff, {OFFSET_FRAC{1'b0}}}));
   assign base_row = $signed(PRODUCT_W'({origin_row_ff, {OFFSET_FRAC{1'b0}}}));
   assign dc_in = mul_flip_ff ? base_col + px_ff : base_col - px_ff;
   assign dr_in = mul_flip_ff ? base_row + py_ff : base_row - py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         add_valid_ff <= 1'b0;
      end else if (advance) begin
         add_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         add_invalid_ff <= mul_invalid_ff;
         add_last_ff <= mul_last_ff;
         dc_ff <= dc_in;
         dr_ff <= dr_in;
      end
   end

   always_comb begin
      qc = dc_ff[PRODUCT_W-1:OFFSET_FRAC]
         + PIXEL_W'(dc_ff[PRODUCT_W-1] && (|dc_ff[OFFSET_FRAC-1:0]));
      qr = dr_ff[PRODUCT_W-1:OFFSET_FRAC]
         + PIXEL_W'(dr_ff[PRODUCT_W-1] && (|dr_ff[OFFSET_FRAC-1:0]));
      wmax = (image_cols_ff > SIDE_W'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE) : image_cols_ff;
      hmax = (image_rows_ff > SIDE_W'(MAX_IMAGE_SIDE)) ? SIDE_W'(MAX_IMAGE_SIDE) : image_rows_ff;
      kept = !add_invalid_ff && !qc[PIXEL_W-1] && !qr[PIXEL_W-1]
         && (qc[PIXEL_W-2:0] < (PIXEL_W-1)'(wmax))
         && (qr[PIXEL_W-2:0] < (PIXEL_W-1)'(hmax));
      rsp_data_in.pixel_col = kept ? qc[9:0] : 10'd0;
      rsp_data_in.pixel_row = kept ? qr[9:0] : 10'd0;
      rsp_data_in.point_kept = kept;
      rsp_data_in.scan_end = add_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= add_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // A kept point always lies inside the configured image.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.point_kept |->
         (11'(rsp_data_ff.pixel_col) < wmax) && (11'(rsp_data_ff.pixel_row) < hmax))
      else $error("kept pixel outside image");

   // A dropped point reports the origin corner of the image.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.point_kept |->
         (rsp_data_ff.pixel_col == 10'd0) && (rsp_data_ff.pixel_row == 10'd0))
      else $error("dropped pixel not cleared");

   // An invalid reading leaving the add stage is never kept.
   assert property (@(posedge clock) disable iff (reset)
      advance && add_valid_ff && add_invalid_ff |=>
         rsp_valid_ff && !rsp_data_ff.point_kept)
      else $error("invalid reading kept");

   // An accepted transaction enters the first pipeline stage.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted transaction lost at entry");

endmodule

// ===== test/scan_point_to_grid_pixel_checker.sv =====
`timescale 1ns / 1ps

module scan_point_to_grid_pixel_checker
   import sptgp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          awaiting,
   output int          kept_points
);

   localparam int REPORT_LIMIT = 40;

   logic [9:0]  org_col;
   logic [9:0]  org_row;
   logic [15:0] cells_per_m;
   logic [10:0] width_px;
   logic [10:0] height_px;
   rsp_type     pixel_queue[$];
   int          errors = 0;
   int          kept = 0;

   function automatic longint toward_zero(longint v);
      if (v >= 0) begin
         return v >>> OFFSET_FRAC;
      end
      return -((-v) >>> OFFSET_FRAC);
   endfunction

   function automatic rsp_type project_point(req_type s);
      longint z;
      longint vx;
      longint vy;
      longint sx;
      longint sy;
      longint sine;
      longint cosine;
      longint scale;
      longint col;
      longint row;
      longint wlim;
      longint hlim;
      logic flip;
      int i;
      rsp_type p;
      p = '0;
      p.scan_end = s.last_sample;
      if (!s.reading_invalid) begin
         z = longint'($signed(s.bearing_q13)) * 32768;
         flip = 1'b0;
         if (z > ANG_HALF_PI) begin
            z -= ANG_PI;
            flip = 1'b1;
         end else if (z < -ANG_HALF_PI) begin
            z += ANG_PI;
            flip = 1'b1;
         end
         vx = CORDIC_GAIN;
         vy = 0;
         for (i = 0; i < CORDIC_STEPS; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (z >= 0) begin
               vx -= sy;
               vy += sx;
               z -= ATAN_TABLE[i];
            end else begin
               vx += sy;
               vy -= sx;
               z += ATAN_TABLE[i];
            end
         end
         sine = flip ? -vy : vy;
         cosine = flip ? -vx : vx;
         scale = longint'(s.range_q8) * longint'(cells_per_m);
         col = toward_zero((longint'(org_col) <<< OFFSET_FRAC) - scale * sine);
         row = toward_zero((longint'(org_row) <<< OFFSET_FRAC) - scale * cosine);
         wlim = (width_px > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : longint'(width_px);
         hlim = (height_px > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : longint'(height_px);
         if (col >= 0 && col < wlim && row >= 0 && row < hlim) begin
            p.point_kept = 1'b1;
            p.pixel_col = col[9:0];
            p.pixel_row = row[9:0];
         end
      end
      return p;
   endfunction

   // Each request transaction is projected when it is accepted, and response
   // transactions must come back in the same order.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         org_col = 10'd100;
         org_row = 10'd185;
         cells_per_m = 16'd5120;
         width_px = 11'd200;
         height_px = 11'd200;
         pixel_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_queue.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: unexpected response, got col %0d row %0d kept %0b end %0b",
                           $time, rsp_data.pixel_col, rsp_data.pixel_row,
                           rsp_data.point_kept, rsp_data.scan_end);
               end
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_data.pixel_col !== want.pixel_col ||
                   rsp_data.pixel_row !== want.pixel_row ||
                   rsp_data.point_kept !== want.point_kept ||
                   rsp_data.scan_end !== want.scan_end) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display({"%0t: pixel mismatch, expected col %0d row %0d kept %0b ",
                               "end %0b, got col %0d row %0d kept %0b end %0b"},
                              $time, want.pixel_col, want.pixel_row, want.point_kept,
                              want.scan_end, rsp_data.pixel_col, rsp_data.pixel_row,
                              rsp_data.point_kept, rsp_data.scan_end);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            want = project_point(req_data);
            if (want.point_kept) begin
               kept++;
            end
            pixel_queue.insert(pixel_queue.size(), want);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_COL: begin
                  org_col = csr_wdata[9:0];
               end
               CSR_ORIGIN_ROW: begin
                  org_row = csr_wdata[9:0];
               end
               CSR_CELLS_PER_METRE: begin
                  cells_per_m = csr_wdata;
               end
               CSR_IMAGE_COLS: begin
                  width_px = csr_wdata[10:0];
               end
               CSR_IMAGE_ROWS: begin
                  height_px = csr_wdata[10:0];
               end
               default: begin
               end
            endcase
         end
      end
      mismatches <= errors;
      awaiting <= pixel_queue.size();
      kept_points <= kept;
   end

endmodule

// ===== test/scan_point_to_grid_pixel_core_test.sv =====
`timescale 1ns / 1ps

module scan_point_to_grid_pixel_core_test;
   import sptgp_pkg::*;

   localparam logic [2:0] CSR_SPARE_LOW = 3'd5;
   localparam logic [2:0] CSR_SPARE_HIGH = 3'd7;
   localparam int PHASES = 8;
   localparam int SAMPLES_PER_PHASE = 192;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int HALF_TURN = 25736;
   localparam int QUARTER_TURN = 12868;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int          mismatches;
   int          awaiting;
   int          kept_points;
   logic        rsp_steady = 1'b0;
   int          hold_ticket = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   bit          send_steady = 1'b0;
   int          samples_sent = 0;
   int          near_range = 2560;

   scan_point_to_grid_pixel_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   scan_point_to_grid_pixel_checker pixel_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .awaiting(awaiting),
      .kept_points(kept_points)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("scan_point_to_grid_pixel_core_test: FAIL");
      $finish;
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         return 0;
      end
      if (pick < 85) begin
         return $urandom_range(1, 3);
      end
      if (pick < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_steady) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            stall_left = idle_length();
         end
      end
   end

   function automatic req_type make_sample(int range, int bearing, bit invalid, bit last);
      req_type s;
      s.range_q8 = 16'(range);
      s.bearing_q13 = 16'(bearing);
      s.reading_invalid = invalid;
      s.last_sample = last;
      return s;
   endfunction

   function automatic req_type random_sample(int near);
      req_type s;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         s.range_q8 = 16'($urandom_range(0, near));
      end else if (pick < 90) begin
         s.range_q8 = 16'($urandom);
      end else if (pick < 95) begin
         s.range_q8 = 16'd0;
      end else begin
         s.range_q8 = 16'hFFFF;
      end
      if ($urandom_range(0, 99) < 80) begin
         s.bearing_q13 = 16'(int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
      end else begin
         s.bearing_q13 = 16'($urandom);
      end
      s.reading_invalid = ($urandom_range(0, 9) == 0);
      s.last_sample = ($urandom_range(0, 15) == 0);
      return s;
   endfunction

   task automatic send_sample(input req_type s);
      int gap;
      gap = send_steady ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_setting(input int p);
      logic [15:0] ocol_w;
      logic [15:0] orow_w;
      logic [15:0] cpm_w;
      logic [15:0] cols_w;
      logic [15:0] rows_w;
      longint side;
      longint near;
      case (p)
         1: begin
            ocol_w = 16'd0;
            orow_w = 16'd0;
            cpm_w = 16'd1;
            cols_w = 16'd1;
            rows_w = 16'd1;
         end
         2: begin
            ocol_w = 16'hFFFF;
            orow_w = 16'hFFFF;
            cpm_w = 16'hFFFF;
            cols_w = 16'hFFFF;
            rows_w = 16'd1024;
         end
         3: begin
            ocol_w = 16'd50;
            orow_w = 16'd1023;
            cpm_w = 16'd0;
            cols_w = 16'd200;
            rows_w = 16'd1024;
         end
         4: begin
            ocol_w = 16'd100;
            orow_w = 16'd185;
            cpm_w = 16'd5120;
            cols_w = 16'd200;
            rows_w = 16'd200;
         end
         5: begin
            ocol_w = 16'd100;
            orow_w = 16'd185;
            cpm_w = 16'd5120;
            cols_w = 16'd0;
            rows_w = 16'd2047;
         end
         default: begin
            ocol_w = 16'($urandom);
            orow_w = 16'($urandom);
            cpm_w = $urandom_range(0, 1) ? 16'($urandom_range(64, 16384)) : 16'($urandom);
            cols_w = 16'($urandom_range(1, 1100));
            rows_w = 16'($urandom_range(1, 1100));
         end
      endcase
      write_reg(CSR_ORIGIN_COL, ocol_w);
      write_reg(CSR_ORIGIN_ROW, orow_w);
      write_reg(CSR_CELLS_PER_METRE, cpm_w);
      write_reg(CSR_IMAGE_COLS, cols_w);
      write_reg(CSR_IMAGE_ROWS, rows_w);
      write_reg((p % 2 == 0) ? CSR_SPARE_LOW : CSR_SPARE_HIGH, 16'($urandom));
      side = (cols_w[10:0] > rows_w[10:0]) ? cols_w[10:0] : rows_w[10:0];
      if (side > MAX_IMAGE_SIDE) begin
         side = MAX_IMAGE_SIDE;
      end
      near = (side * 65536) / ((cpm_w == 0) ? 1 : cpm_w);
      near_range = (near > 65535) ? 65535 : ((near < 1) ? 1 : int'(near));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_sample(make_sample(0, 0, 1'b0, 1'b0));
      send_sample(make_sample(65535, 0, 1'b0, 1'b0));
      send_sample(make_sample(256, QUARTER_TURN, 1'b0, 1'b0));
      send_sample(make_sample(256, QUARTER_TURN + 1, 1'b0, 1'b0));
      send_sample(make_sample(256, -QUARTER_TURN, 1'b0, 1'b0));
      send_sample(make_sample(256, -QUARTER_TURN - 1, 1'b0, 1'b0));
      send_sample(make_sample(256, HALF_TURN, 1'b0, 1'b0));
      send_sample(make_sample(256, -HALF_TURN, 1'b0, 1'b0));
      send_sample(make_sample(256, 32767, 1'b0, 1'b1));
      send_sample(make_sample(256, -32768, 1'b0, 1'b0));
      send_sample(make_sample(1277, -QUARTER_TURN, 1'b0, 1'b0));
      send_sample(make_sample(1280, -QUARTER_TURN, 1'b0, 1'b0));
      send_sample(make_sample(1280, QUARTER_TURN, 1'b0, 1'b0));
      send_sample(make_sample(1300, QUARTER_TURN, 1'b0, 1'b0));
      send_sample(make_sample(2368, 0, 1'b0, 1'b0));
      send_sample(make_sample(2400, 0, 1'b0, 1'b0));
      send_sample(make_sample(179, HALF_TURN, 1'b0, 1'b0));
      send_sample(make_sample(192, HALF_TURN, 1'b0, 1'b0));
      send_sample(make_sample(256, 0, 1'b1, 1'b0));
      send_sample(make_sample(65535, -32768, 1'b1, 1'b1));
      send_sample(make_sample(65535, 32767, 1'b0, 1'b1));
      send_sample(make_sample(0, -32768, 1'b0, 1'b0));
      send_sample(make_sample(128, 4096, 1'b0, 1'b0));

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            apply_setting(p);
         end
         send_steady = (p == 2 || p == 3);
         rsp_steady <= (p == 3);
         if (p == 2) begin
            hold_ticket <= hold_ticket + 1;
         end
         for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
            send_sample(random_sample(near_range));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d samples under %0d register settings; %0d landed inside the image.",
               samples_sent, PHASES, kept_points);
      $display("It went through folded bearings, invalid readings, clamped and empty images.");
      if (mismatches == 0) begin
         $display("scan_point_to_grid_pixel_core_test: PASS");
      end else begin
         $display("scan_point_to_grid_pixel_core_test: FAIL");
      end
      $finish;
   end

endmodule
